### sv/ilst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilst_pkg: shared types and constants of the indexed ordered list
// Command codes, field widths, cell control word and controller states.
// ---------------------------------------------------------------------------
package ilst_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 12;
    localparam int CMD_W     = 3;
    localparam int OUT_CNT_W = 9;
    localparam int GROUP     = 16;

    localparam logic [CMD_W-1:0] CMD_GET  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL  = 3'd4;

    localparam logic [DATA_W-1:0] NOT_FOUND = '1;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic              up;
        logic              dn;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

### sv/ilst_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilst_if: request and response channels of the indexed ordered list
// Valid/ready channels; an item moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface ilst_req_if;
    logic                                valid;
    logic                                ready;
    logic [ilst_pkg::CMD_W-1:0]          command;
    logic [ilst_pkg::POS_W-1:0]          position;
    logic signed [ilst_pkg::DATA_W-1:0]  value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface ilst_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [ilst_pkg::DATA_W-1:0]  read_value;
    logic                                found;
    logic                                accepted;
    logic [ilst_pkg::OUT_CNT_W-1:0]      entry_count;

    modport source (output valid, read_value, found, accepted, entry_count, input ready);
    modport sink   (input valid, read_value, found, accepted, entry_count, output ready);
endinterface

### sv/ilst_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilst_cell: one list slot
// Holds one value; takes the left neighbor on an insert below it, the new
// value at the insert point, the right neighbor on a delete at or below it.
// ---------------------------------------------------------------------------
module ilst_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  ilst_pkg::t_cell_ctl           i_ctl,
    input  logic [ilst_pkg::DATA_W-1:0]   i_left,
    input  logic [ilst_pkg::DATA_W-1:0]   i_right,
    output logic [ilst_pkg::DATA_W-1:0]   o_value,
    output logic [ilst_pkg::DATA_W-1:0]   o_rd
);

    localparam logic [ilst_pkg::POS_W-1:0] MY_IDX = ilst_pkg::POS_W'(IDX);

    logic [ilst_pkg::DATA_W-1:0] r_value;
    logic [ilst_pkg::DATA_W-1:0] n_value;
    logic                        hit;
    logic                        above;

    assign hit   = (i_ctl.pos == MY_IDX);
    assign above = (MY_IDX > i_ctl.pos);

    // Pick the next slot content
    always_comb begin
        n_value = r_value;
        if (i_ctl.up) begin
            if (above) begin
                n_value = i_left;
            end else if (hit) begin
                n_value = i_ctl.value;
            end
        end else if (i_ctl.dn) begin
            if (above || hit) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    // Drive the read bus only from the addressed slot
    assign o_rd    = hit ? r_value : '0;

endmodule

### sv/ilst_group.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilst_group: registered read merge over a group of cells
// ORs the read words of one group; at most one of them is nonzero.
// ---------------------------------------------------------------------------
module ilst_group (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [ilst_pkg::DATA_W-1:0]   i_words [ilst_pkg::GROUP],
    output logic [ilst_pkg::DATA_W-1:0]   o_word
);

    logic [ilst_pkg::DATA_W-1:0] r_word;
    logic [ilst_pkg::DATA_W-1:0] merged;

    // Merge the group
    always_comb begin
        merged = '0;
        for (int k = 0; k < ilst_pkg::GROUP; k++) begin
            merged = merged | i_words[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= merged;
        end
    end

    assign o_word = r_word;

endmodule

### sv/indexed_ordered_list_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_ordered_list_core: ordered list in a shifting row of cells
// Get, add at head/tail/index and delete over up to CAPACITY values.
// ---------------------------------------------------------------------------
//  channel   dir   handshake         payload
//  i_req     in    valid / ready     command, position, value
//  o_rsp     out   valid / ready     read_value, found, accepted, entry_count
//
//  An item is accepted in the idle state; then, in the exec state, the row of
//  cells shifts and each group of 16 cells registers its read word; then the
//  done state merges the groups into the output register.
//  i_req.ready is high only while the controller is idle.
//  A result held in o_rsp stalls the merge cycle until it is taken.
//  Synchronous reset clears the count and control; the cells are not cleared.
// ---------------------------------------------------------------------------
module indexed_ordered_list_core #(
    parameter int CAPACITY = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ilst_req_if.sink       i_req,
    ilst_rsp_if.source     o_rsp
);

    localparam int DW      = ilst_pkg::DATA_W;
    localparam int PW      = ilst_pkg::POS_W;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > PW) ? CNT_W : PW;
    localparam int EXT_W   = (CNT_W > ilst_pkg::OUT_CNT_W) ? CNT_W : ilst_pkg::OUT_CNT_W;
    localparam int NG      = (CAPACITY + ilst_pkg::GROUP - 1) / ilst_pkg::GROUP;

    ilst_pkg::t_state r_state;
    ilst_pkg::t_state n_state;

    logic [ilst_pkg::CMD_W-1:0] r_cmd;
    logic [PW-1:0]              r_pos;
    logic [DW-1:0]              r_val;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_found;
    logic                       r_acc;

    logic                       r_out_valid;
    logic [DW-1:0]              r_out_rd;
    logic                       r_out_found;
    logic                       r_out_acc;
    logic [ilst_pkg::OUT_CNT_W-1:0] r_out_cnt;

    logic [CMP_W-1:0] cmp_count;
    logic [CMP_W-1:0] cmp_pos;
    logic [CMP_W-1:0] ins_pos;
    logic             is_add;
    logic             full;
    logic             ins_ok;
    logic             del_ok;
    logic             get_ok;
    logic             exec;
    logic             load_out;
    logic [EXT_W-1:0] cnt_ext;
    logic [DW-1:0]    merged;

    ilst_pkg::t_cell_ctl ctl;

    logic [DW-1:0] cell_val [CAPACITY];
    logic [DW-1:0] cell_rd  [CAPACITY];
    logic [DW-1:0] grp_word [NG];

    assign exec     = (r_state == ilst_pkg::S_EXEC);
    assign load_out = (r_state == ilst_pkg::S_DONE) && (!r_out_valid || o_rsp.ready);

    // Decode the held command against the count
    always_comb begin
        cmp_count = CMP_W'(r_count);
        cmp_pos   = CMP_W'(r_pos);
        is_add    = (r_cmd == ilst_pkg::CMD_HEAD) || (r_cmd == ilst_pkg::CMD_TAIL)
                    || (r_cmd == ilst_pkg::CMD_AT);
        if (r_cmd == ilst_pkg::CMD_HEAD) begin
            ins_pos = '0;
        end else if (r_cmd == ilst_pkg::CMD_TAIL) begin
            ins_pos = cmp_count;
        end else begin
            ins_pos = cmp_pos;
        end
        full   = (r_count == CNT_W'(CAPACITY));
        ins_ok = is_add && !full && (ins_pos <= cmp_count);
        del_ok = (r_cmd == ilst_pkg::CMD_DEL) && (cmp_pos < cmp_count);
        get_ok = (r_cmd == ilst_pkg::CMD_GET) && (cmp_pos < cmp_count);
    end

    // Broadcast the shift to the row
    always_comb begin
        ctl.up    = exec && ins_ok;
        ctl.dn    = exec && del_ok;
        ctl.pos   = is_add ? PW'(ins_pos) : r_pos;
        ctl.value = r_val;
    end

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DW-1:0] left_w;
        logic [DW-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = cell_val[i];
        end else begin : g_mid_l
            assign left_w = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_w = cell_val[i];
        end else begin : g_mid_r
            assign right_w = cell_val[i+1];
        end
        ilst_cell #(.IDX(i)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  (left_w),
            .i_right (right_w),
            .o_value (cell_val[i]),
            .o_rd    (cell_rd[i])
        );
    end

    // Read merge, first level
    for (genvar g = 0; g < NG; g++) begin : g_grp
        logic [DW-1:0] words [ilst_pkg::GROUP];
        for (genvar k = 0; k < ilst_pkg::GROUP; k++) begin : g_w
            if (g * ilst_pkg::GROUP + k < CAPACITY) begin : g_in
                assign words[k] = cell_rd[g * ilst_pkg::GROUP + k];
            end else begin : g_pad
                assign words[k] = '0;
            end
        end
        ilst_group u_grp (
            .i_clk   (i_clk),
            .i_en    (exec),
            .i_words (words),
            .o_word  (grp_word[g])
        );
    end

    // Read merge, second level
    always_comb begin
        merged = '0;
        for (int g = 0; g < NG; g++) begin
            merged = merged | grp_word[g];
        end
    end

    // Advance the controller
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ilst_pkg::S_IDLE: begin
                if (i_req.valid) n_state = ilst_pkg::S_EXEC;
            end
            ilst_pkg::S_EXEC: begin
                n_state = ilst_pkg::S_DONE;
            end
            ilst_pkg::S_DONE: begin
                if (load_out) n_state = ilst_pkg::S_IDLE;
            end
            default: begin
                n_state = ilst_pkg::S_IDLE;
            end
        endcase
    end

    // Update the count
    always_comb begin
        n_count = r_count;
        if (exec && ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (exec && del_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ilst_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the command and the decision
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd <= i_req.command;
            r_pos <= i_req.position;
            r_val <= i_req.value;
        end
        if (exec) begin
            r_found <= get_ok;
            r_acc   <= get_ok || ins_ok || del_ok;
        end
    end

    assign cnt_ext = EXT_W'(r_count);

    // Load the result
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_rd    <= r_found ? merged : ilst_pkg::NOT_FOUND;
            r_out_found <= r_found;
            r_out_acc   <= r_acc;
            r_out_cnt   <= cnt_ext[ilst_pkg::OUT_CNT_W-1:0];
        end
    end

    assign i_req.ready       = (r_state == ilst_pkg::S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out_rd;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.accepted    = r_out_acc;
    assign o_rsp.entry_count = r_out_cnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count past capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec |=> r_count == $past(r_count))
        else $error("count moved outside the shift cycle");

    a_found_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.found |-> o_rsp.accepted)
        else $error("found without accepted");

    a_miss_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.found |-> o_rsp.read_value == ilst_pkg::NOT_FOUND)
        else $error("miss without all-ones value");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.read_value))
        else $error("pending result overwritten");

endmodule
